// ===== rtl/core/dds_pkg.sv =====
// package for the decimal digit sorter: widths, stage types and the binary to bcd step
package dds_pkg;

  localparam int NUM_W      = 31;
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = DIGIT_W * MAX_DIGITS;
  localparam int CNT_W      = 4;
  localparam int RADIX      = 10;
  localparam int THRESH_N   = RADIX - 1;

  // double dabble iterations done in each conversion stage
  localparam int DD_STAGES     = 4;
  localparam int DD_STEPS      = 8;
  localparam int DD_STEPS_LAST = NUM_W - (DD_STAGES - 1) * DD_STEPS;

  // total register stages from input to output
  localparam int NUM_STAGES = DD_STAGES + 3;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [NUM_W-1:0] bin;
  } dd_t;

  typedef logic [THRESH_N-1:0][MAX_DIGITS-1:0] lt_t;
  typedef logic [THRESH_N-1:0][CNT_W-1:0]      cum_t;

  // one shift-and-add-3 iteration, msb of bin moves into the bcd field
  function automatic dd_t dd_step(dd_t s);
    dd_t r;
    r = s;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      if (r.bcd[DIGIT_W*p +: DIGIT_W] >= DIGIT_W'(5)) begin
        r.bcd[DIGIT_W*p +: DIGIT_W] = r.bcd[DIGIT_W*p +: DIGIT_W] + DIGIT_W'(3);
      end
    end
    r.bcd = {r.bcd[BCD_W-2:0], r.bin[NUM_W-1]};
    r.bin = {r.bin[NUM_W-2:0], 1'b0};
    return r;
  endfunction

  function automatic dd_t dd_run(dd_t s, int steps);
    dd_t r;
    r = s;
    for (int i = 0; i < DD_STEPS; i++) begin
      if (i < steps) begin
        r = dd_step(r);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/decimal_digit_sorter.sv =====
// decimal digit sorter top level: binary to bcd, digit ranking and sorted bcd outputs
//
// input channel: number with in_valid / in_stall, an item is taken when
// in_valid is high and in_stall is low. output channel: largest_bcd,
// smallest_bcd and digit_count with out_valid / out_stall.
// each item gives one result: its decimal digits sorted descending and
// ascending as right-aligned packed bcd, and the number of digits (one for 0).
// the block is a seven stage pipeline: four stages of binary to bcd
// conversion (eight shift-add-3 steps each, seven in the last), one stage
// for digit length and rank masks, one for rank counts, one that builds the
// sorted bcd words. throughput is one item per cycle while out_stall is low.
// when the receiver stalls, results hold at the output and empty stages
// still fill, so in_stall rises only once all seven stages hold items.
// reset clears the stage valid bits; the datapath registers are not reset.
module decimal_digit_sorter
  import dds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [NUM_W-1:0]   number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BCD_W-1:0]   largest_bcd,
  output logic [BCD_W-1:0]   smallest_bcd,
  output logic [CNT_W-1:0]   digit_count
);

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES:0]   en;

  dd_t  dd0, dd1, dd2, dd3;
  dd_t  dd_in;
  logic [CNT_W-1:0] n4, n5;
  lt_t  lt4;
  cum_t cum5;

  logic [CNT_W-1:0] n_next;
  lt_t              lt_next;
  cum_t             cum_next;
  logic [BCD_W-1:0] large_next, small_next;

  // a stage loads when it is empty or the stage after it moves
  always_comb begin
    en[NUM_STAGES] = !out_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !stage_valid[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = stage_valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign dd_in = '{bcd: '0, bin: number};

  // rank masks: bit p of lt[t] marks a digit at position p below t+1
  always_comb begin
    n_next  = CNT_W'(1);
    lt_next = '0;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      if (dd3.bcd[DIGIT_W*p +: DIGIT_W] != '0) begin
        n_next = CNT_W'(p + 1);
      end
    end
    for (int t = 0; t < THRESH_N; t++) begin
      for (int p = 0; p < MAX_DIGITS; p++) begin
        lt_next[t][p] = (CNT_W'(p) < n_next) &&
                        (dd3.bcd[DIGIT_W*p +: DIGIT_W] < DIGIT_W'(t + 1));
      end
    end
  end

  always_comb begin
    for (int t = 0; t < THRESH_N; t++) begin
      cum_next[t] = CNT_W'($countones(lt4[t]));
    end
  end

  // the digit at ascending rank i is the number of thresholds whose count is <= i
  always_comb begin
    logic [CNT_W-1:0]    idx_s;
    logic [THRESH_N-1:0] ml;
    logic [THRESH_N-1:0] ms;
    large_next = '0;
    small_next = '0;
    idx_s      = '0;
    ml         = '0;
    ms         = '0;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      if (CNT_W'(p) < n5) begin
        idx_s = n5 - CNT_W'(1) - CNT_W'(p);
        for (int t = 0; t < THRESH_N; t++) begin
          ml[t] = cum5[t] <= CNT_W'(p);
          ms[t] = cum5[t] <= idx_s;
        end
        large_next[DIGIT_W*p +: DIGIT_W] = DIGIT_W'($countones(ml));
        small_next[DIGIT_W*p +: DIGIT_W] = DIGIT_W'($countones(ms));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dd0 <= dd_run(dd_in, DD_STEPS);
    end
    if (en[1]) begin
      dd1 <= dd_run(dd0, DD_STEPS);
    end
    if (en[2]) begin
      dd2 <= dd_run(dd1, DD_STEPS);
    end
    if (en[3]) begin
      dd3 <= dd_run(dd2, DD_STEPS_LAST);
    end
    if (en[4]) begin
      n4  <= n_next;
      lt4 <= lt_next;
    end
    if (en[5]) begin
      n5   <= n4;
      cum5 <= cum_next;
    end
    if (en[6]) begin
      largest_bcd  <= large_next;
      smallest_bcd <= small_next;
      digit_count  <= n5;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_count >= CNT_W'(1)) && (digit_count <= CNT_W'(MAX_DIGITS)))
    else $error("digit count out of range");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> largest_bcd >= smallest_bcd)
    else $error("largest below smallest");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !(&stage_valid) |-> !in_stall)
    else $error("input stalled with an empty stage");
`endif

endmodule
